// ===== hw/rtl/rert_pkg.sv =====
// ----------------------------------------------------------------------------
// rert_pkg: shared types and constants of the reliable event retry table
// request and result codes, entry layout, register reset values
// ----------------------------------------------------------------------------
package rert_pkg;

  // table geometry
  localparam int TableDepthDef = 16;
  localparam int MaxResults    = 16;

  // field widths
  localparam int ReqW     = 2;
  localparam int EvW      = 8;
  localparam int TxidW    = 32;
  localparam int AttW     = 4;
  localparam int TimeW    = 32;
  localparam int IvlW     = 16;
  localparam int KindW    = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // register reset values
  localparam logic [IvlW-1:0] RetryIntervalRst = 16'd100;
  localparam logic [AttW-1:0] MaxAttemptsRst   = 4'd3;
  localparam logic            RetryEnableRst   = 1'b1;

  typedef enum logic [ReqW-1:0] {
    REQ_QUEUE = 2'd0,
    REQ_ACK   = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_e;

  typedef enum logic [KindW-1:0] {
    KIND_SEND    = 3'd0,
    KIND_RESEND  = 3'd1,
    KIND_TIMEOUT = 3'd2,
    KIND_ACKED   = 3'd3,
    KIND_NOACK   = 3'd4,
    KIND_FULL    = 3'd5
  } result_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RETRY_INTERVAL = 2'd0,
    CFG_MAX_ATTEMPTS   = 2'd1,
    CFG_RETRY_ENABLE   = 2'd2
  } cfg_index_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // one stored table entry
  typedef struct packed {
    logic [EvW-1:0]   event_type;
    logic [TxidW-1:0] txid;
    logic [AttW-1:0]  attempts;
    logic [TimeW-1:0] deadline;
  } entry_t;

  // one result item
  typedef struct packed {
    result_kind_e     kind;
    logic [EvW-1:0]   event_type;
    logic [TxidW-1:0] txid;
    logic [AttW-1:0]  attempt;
  } result_t;

endpackage

// ===== hw/rtl/reliable_event_retry_table.sv =====
// ----------------------------------------------------------------------------
// reliable_event_retry_table: pending reliable events awaiting acknowledge
// queue, ack, tick and clear requests over a table of retry entries
// ----------------------------------------------------------------------------
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------------
//  request | in_valid_i / in_stall_o     | req_type_i, event_type_i, ack_txid_i
//  result  | out_valid_o / out_stall_i   | result_kind_o, result_event_type_o,
//          |                             | result_txid_o, attempt_number_o,
//          |                             | last_result_o
//  config  | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
//  queue and clear requests and disabled ticks are handled in idle, without a scan
//  ack and enabled tick requests scan the entry memory one slot per cycle
//  through its single read port, whose read data is registered
//  an ack stops the scan at its first matching slot
//  a result that cannot move on freezes the scan until the result side frees
//  reset clears the valid bits at once; entry memory needs no clearing pass
//
module reliable_event_retry_table import rert_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ReqW-1:0]     req_type_i,
  input  logic [EvW-1:0]      event_type_i,
  input  logic [TxidW-1:0]    ack_txid_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [KindW-1:0]    result_kind_o,
  output logic [EvW-1:0]      result_event_type_o,
  output logic [TxidW-1:0]    result_txid_o,
  output logic [AttW-1:0]     attempt_number_o,
  output logic                last_result_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(MaxResults + 1);
  localparam logic [IdxW:0]   ScanEnd  = (IdxW + 1)'(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(TABLE_DEPTH - 1);
  localparam logic [CntW-1:0] CapLast  = CntW'(MaxResults - 1);

  // configuration registers
  logic [IvlW-1:0] ivl_q;
  logic [AttW-1:0] max_att_q;
  logic            en_q;

  // global state
  logic [TimeW-1:0]       time_q;
  logic [TxidW-1:0]       next_txid_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  // scan control
  state_e             state_q, state_d;
  logic               op_ack_q;
  logic [TxidW-1:0]   ack_txid_q;
  logic [IdxW:0]      rd_idx_q;
  logic               ev_vld_q;
  logic [IdxW-1:0]    ev_idx_q;
  logic [CntW-1:0]    res_cnt_q;

  // result hold stage and output register
  logic    hold_vld_q, hold_final_q;
  result_t hold_res_q;
  logic    out_vld_q, out_last_q;
  result_t out_res_q;

  // memory port
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  entry_t          mem_wdata, ent;

  // control
  req_type_e        req;
  logic             in_acc, cfg_we;
  logic             out_free, can_push, hold_move;
  logic             push, push_final, set_final, finish, frozen;
  result_t          push_res;
  logic             free_found;
  logic [IdxW-1:0]  free_idx;
  logic             slot_live, due, expired, hit, last_slot, scan_found;
  logic [TimeW-1:0] diff, new_deadline;

  assign req          = req_type_e'(req_type_i);
  assign out_free     = !out_vld_q || !out_stall_i;
  // a new result may enter the hold stage when it is empty or drains now
  assign can_push     = !hold_vld_q || out_free;
  assign in_stall_o   = (state_q != ST_IDLE) || !can_push;
  assign in_acc       = in_valid_i && !in_stall_o;
  assign cfg_ready_o  = 1'b1;
  assign cfg_we       = cfg_valid_i && cfg_ready_o;
  assign new_deadline = time_q + {{(TimeW - IvlW){1'b0}}, ivl_q};

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  // evaluation of the slot whose entry is on the read data
  always_comb begin
    slot_live  = valid_q[ev_idx_q];
    diff       = time_q - ent.deadline;
    // due once time has reached the deadline, modulo wrap
    due        = slot_live && !diff[TimeW-1];
    expired    = ent.attempts >= max_att_q;
    hit        = slot_live && (ent.txid == ack_txid_q);
    last_slot  = ev_idx_q == LastSlot;
    // an ack always reports something at the last slot
    scan_found = op_ack_q ? (hit || last_slot) : due;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && ((req == REQ_ACK) || ((req == REQ_TICK) && en_q))) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    push       = 1'b0;
    push_final = 1'b0;
    push_res   = '0;
    set_final  = 1'b0;
    finish     = 1'b0;
    frozen     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = free_idx;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = rd_idx_q[IdxW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (req == REQ_QUEUE)) begin
          push       = 1'b1;
          push_final = 1'b1;
          if (free_found) begin
            mem_we    = 1'b1;
            mem_wdata = '{event_type: event_type_i, txid: next_txid_q,
                          attempts: AttW'(1), deadline: new_deadline};
            push_res  = '{kind: KIND_SEND, event_type: event_type_i,
                          txid: next_txid_q, attempt: AttW'(1)};
          end else begin
            push_res  = '{kind: KIND_FULL, event_type: event_type_i,
                          txid: '0, attempt: '0};
          end
        end
      end
      ST_SCAN: begin
        // hold the read data while a result cannot be placed
        frozen = ev_vld_q && scan_found && !can_push;
        mem_re = !frozen && (rd_idx_q < ScanEnd);
        if (ev_vld_q && !frozen) begin
          push = scan_found;
          if (op_ack_q) begin
            finish     = scan_found;
            push_final = 1'b1;
            if (hit) begin
              push_res = '{kind: KIND_ACKED, event_type: ent.event_type,
                           txid: ent.txid, attempt: ent.attempts};
            end else begin
              push_res = '{kind: KIND_NOACK, event_type: '0,
                           txid: ack_txid_q, attempt: '0};
            end
          end else begin
            // stop at the last slot or once the result cap is reached
            finish     = last_slot || (due && (res_cnt_q == CapLast));
            push_final = finish;
            set_final  = finish && !due;
            if (expired) begin
              push_res = '{kind: KIND_TIMEOUT, event_type: ent.event_type,
                           txid: ent.txid, attempt: ent.attempts};
            end else begin
              push_res = '{kind: KIND_RESEND, event_type: ent.event_type,
                           txid: ent.txid, attempt: ent.attempts + AttW'(1)};
              // renew the entry in place
              mem_we    = due;
              mem_waddr = ev_idx_q;
              mem_wdata = '{event_type: ent.event_type, txid: ent.txid,
                            attempts: ent.attempts + AttW'(1),
                            deadline: new_deadline};
            end
          end
        end
      end
      default: ;
    endcase
  end

  // the held result leaves once its successor arrives or it is known final
  assign hold_move = hold_vld_q && out_free && (hold_final_q || push);

  rert_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (ent)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivl_q     <= RetryIntervalRst;
      max_att_q <= MaxAttemptsRst;
      en_q      <= RetryEnableRst;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_RETRY_INTERVAL: ivl_q     <= cfg_data_i;
        CFG_MAX_ATTEMPTS:   max_att_q <= cfg_data_i[AttW-1:0];
        CFG_RETRY_ENABLE:   en_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // time, transaction ids and slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      next_txid_q <= TxidW'(1);
      valid_q     <= '0;
    end else begin
      if (in_acc) begin
        case (req)
          REQ_QUEUE: begin
            if (free_found) begin
              valid_q[free_idx] <= 1'b1;
              // ids wrap and skip zero
              if (next_txid_q == '1) begin
                next_txid_q <= TxidW'(1);
              end else begin
                next_txid_q <= next_txid_q + TxidW'(1);
              end
            end
          end
          REQ_TICK: begin
            if (en_q) begin
              time_q <= time_q + TimeW'(1);
            end
          end
          REQ_CLEAR: valid_q <= '0;
          default: ;
        endcase
      end
      // drop acked or timed-out entries
      if ((state_q == ST_SCAN) && ev_vld_q && !frozen) begin
        if ((op_ack_q && hit) || (!op_ack_q && due && expired)) begin
          valid_q[ev_idx_q] <= 1'b0;
        end
      end
    end
  end

  // scan sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_ack_q   <= 1'b0;
      ack_txid_q <= '0;
      rd_idx_q   <= '0;
      ev_vld_q   <= 1'b0;
      ev_idx_q   <= '0;
      res_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        op_ack_q   <= req == REQ_ACK;
        ack_txid_q <= ack_txid_i;
        rd_idx_q   <= '0;
        ev_vld_q   <= 1'b0;
        res_cnt_q  <= '0;
      end else if (state_q == ST_SCAN) begin
        if (finish) begin
          ev_vld_q <= 1'b0;
        end else if (!frozen) begin
          ev_vld_q <= mem_re;
          ev_idx_q <= rd_idx_q[IdxW-1:0];
          if (mem_re) begin
            rd_idx_q <= rd_idx_q + (IdxW + 1)'(1);
          end
        end
        if (push && !op_ack_q) begin
          res_cnt_q <= res_cnt_q + CntW'(1);
        end
      end
    end
  end

  // hold stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q   <= 1'b0;
      hold_final_q <= 1'b0;
      out_vld_q    <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      if (push) begin
        hold_vld_q   <= 1'b1;
        hold_final_q <= push_final;
      end else if (hold_move) begin
        hold_vld_q   <= 1'b0;
        hold_final_q <= 1'b0;
      end else if (set_final && hold_vld_q) begin
        hold_final_q <= 1'b1;
      end
      if (hold_move) begin
        out_vld_q  <= 1'b1;
        out_last_q <= hold_final_q;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payloads
  always_ff @(posedge clk_i) begin
    if (push) begin
      hold_res_q <= push_res;
    end
    if (hold_move) begin
      out_res_q <= hold_res_q;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign result_kind_o       = out_res_q.kind;
  assign result_event_type_o = out_res_q.event_type;
  assign result_txid_o       = out_res_q.txid;
  assign attempt_number_o    = out_res_q.attempt;
  assign last_result_o       = out_last_q;

  // write-back never hits the slot being read in the same cycle
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("entry memory read and write at the same slot");

  // transaction id zero is never handed out
  a_txid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_txid_q != '0)
    else $error("next transaction id is zero");

  // once a scan is over, any held result carries the last flag
  a_idle_hold_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!hold_vld_q || hold_final_q))
    else $error("held result not marked last after scan");

  // time only moves on an accepted enabled tick
  a_time_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q != $past(time_q)) |-> $past(in_acc && (req == REQ_TICK) && en_q))
    else $error("time advanced without a tick request");

endmodule

// ===== hw/rtl/rert_mem.sv =====
// ----------------------------------------------------------------------------
// rert_mem: entry storage of the retry table
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rert_mem import rert_pkg::*; #(
  parameter int DEPTH = TableDepthDef,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the reliable event retry table
// drives queue, ack, tick and clear requests under random gaps and result
// stalls, predicts every result from a local copy of the table and compares
// each delivered result field by field, over several register settings
// ----------------------------------------------------------------------------
module tb_top;
  import rert_pkg::*;

  localparam int Depth      = TableDepthDef;
  localparam int SettleCyc  = 2 * Depth + 8;  // quiet cycles for requests with no result
  localparam int RunLimitNs = 10_000_000;      // hang guard limit, in nanoseconds

  // one request as the driver presents it
  typedef struct packed {
    req_type_e        rq;
    logic [EvW-1:0]   ev;
    logic [TxidW-1:0] ack;
  } request_t;

  // one predicted result, with the end-of-request flag
  typedef struct packed {
    result_kind_e     kind;
    logic [EvW-1:0]   ev;
    logic [TxidW-1:0] txid;
    logic [AttW-1:0]  att;
    logic             last;
  } outcome_t;

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_LONG,
    STALL_TOGGLE
  } stall_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ReqW-1:0]     req_type_i = '0;
  logic [EvW-1:0]      event_type_i = '0;
  logic [TxidW-1:0]    ack_txid_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [KindW-1:0]    result_kind_o;
  logic [EvW-1:0]      result_event_type_o;
  logic [TxidW-1:0]    result_txid_o;
  logic [AttW-1:0]     attempt_number_o;
  logic                last_result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  reliable_event_retry_table dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type_i),
    .event_type_i        (event_type_i),
    .ack_txid_i          (ack_txid_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .result_kind_o       (result_kind_o),
    .result_event_type_o (result_event_type_o),
    .result_txid_o       (result_txid_o),
    .attempt_number_o    (attempt_number_o),
    .last_result_o       (last_result_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // table predictor: mirror of the pending-event table and its registers
  // --------------------------------------------------------------------------
  logic [IvlW-1:0]  cfg_interval = RetryIntervalRst;
  logic [AttW-1:0]  cfg_max_att  = MaxAttemptsRst;
  logic             cfg_enable   = RetryEnableRst;
  logic [TimeW-1:0] clock_now    = '0;
  logic [TxidW-1:0] txid_next    = 32'd1;
  bit               tbl_used [Depth];
  entry_t           tbl      [Depth];

  outcome_t pending_results [$];  // results still owed by the block
  request_t todo_q [$];           // requests waiting for the driver

  int n_queued, n_accepted, n_checked, n_faults, n_settings;
  int kind_seen [6];

  function automatic outcome_t pack_result(result_kind_e k, logic [EvW-1:0] e,
                                           logic [TxidW-1:0] t, logic [AttW-1:0] a);
    outcome_t o;
    o.kind = k;
    o.ev   = e;
    o.txid = t;
    o.att  = a;
    o.last = 1'b0;
    return o;
  endfunction

  // works out the results of one accepted request and updates the mirror
  function automatic void predict_request(req_type_e rq, logic [EvW-1:0] ev,
                                          logic [TxidW-1:0] ack);
    outcome_t         res [$];
    int               slot;
    logic [TimeW-1:0] lag;
    slot = -1;
    case (rq)
      REQ_QUEUE: begin
        // lowest free slot takes the event
        for (int i = 0; i < Depth; i++)
          if (!tbl_used[i] && slot < 0) slot = i;
        if (slot < 0) begin
          // full table: dropped, no id consumed
          res.push_back(pack_result(KIND_FULL, ev, '0, '0));
        end else begin
          tbl_used[slot]       = 1'b1;
          tbl[slot].event_type = ev;
          tbl[slot].txid       = txid_next;
          tbl[slot].attempts   = 4'd1;
          tbl[slot].deadline   = clock_now + {16'h0, cfg_interval};
          res.push_back(pack_result(KIND_SEND, ev, txid_next, 4'd1));
          // ids wrap and never take the value zero
          txid_next = txid_next + 1;
          if (txid_next == '0) txid_next = 32'd1;
        end
      end
      REQ_ACK: begin
        for (int i = 0; i < Depth; i++)
          if (tbl_used[i] && tbl[i].txid == ack && slot < 0) slot = i;
        if (slot < 0) begin
          res.push_back(pack_result(KIND_NOACK, '0, ack, '0));
        end else begin
          tbl_used[slot] = 1'b0;
          res.push_back(pack_result(KIND_ACKED, tbl[slot].event_type, tbl[slot].txid,
                                    tbl[slot].attempts));
        end
      end
      REQ_TICK: begin
        // disabled retries freeze time as well
        if (cfg_enable) begin
          clock_now = clock_now + 1;
          for (int i = 0; i < Depth; i++) begin
            lag = clock_now - tbl[i].deadline;
            if (tbl_used[i] && !lag[TimeW-1] && res.size() < MaxResults) begin
              if (tbl[i].attempts >= cfg_max_att) begin
                tbl_used[i] = 1'b0;
                res.push_back(pack_result(KIND_TIMEOUT, tbl[i].event_type, tbl[i].txid,
                                          tbl[i].attempts));
              end else begin
                tbl[i].attempts = tbl[i].attempts + 4'd1;
                tbl[i].deadline = clock_now + {16'h0, cfg_interval};
                res.push_back(pack_result(KIND_RESEND, tbl[i].event_type, tbl[i].txid,
                                          tbl[i].attempts));
              end
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < Depth; i++) tbl_used[i] = 1'b0;
      end
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endfunction

  task automatic flag_error(string msg);
    n_faults++;
    if (n_faults <= 10) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // request driver: bursts of requests with random gaps between bursts
  // --------------------------------------------------------------------------
  bit       req_taken;
  int       burst_left = 1;
  int       gap_left;
  request_t next_req;

  // acceptance is seen at the rising edge, prediction follows right away
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_request(req_type_e'(req_type_i), event_type_i, ack_txid_i);
      n_accepted++;
      req_taken = 1'b1;
    end
  end

  // new request only once the held one is gone, so a stalled payload stays put
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (todo_q.size() > 0) begin
        next_req = todo_q.pop_front();
        in_valid_i   <= 1'b1;
        req_type_i   <= next_req.rq;
        event_type_i <= next_req.ev;
        ack_txid_i   <= next_req.ack;
        if (burst_left <= 1) begin
          // a quarter of the bursts run straight into the next one
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: stall pattern whose style switches after a randomly drawn run of cycles
  // --------------------------------------------------------------------------
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_cnt;
  int          hold_cnt;
  bit          hold_val;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_cnt == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_cnt  = $urandom_range(100, 300);
      end else begin
        stall_cnt--;
      end
      case (stall_mode)
        STALL_NONE:   out_stall_i <= 1'b0;
        STALL_SPARSE: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_LONG: begin
          // alternating stretches of stall and flow
          if (hold_cnt == 0) begin
            hold_val = !hold_val;
            hold_cnt = hold_val ? $urandom_range(1, 12) : $urandom_range(1, 6);
          end else begin
            hold_cnt--;
          end
          out_stall_i <= hold_val;
        end
        default:      out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every delivered result against the oldest one owed
  // --------------------------------------------------------------------------
  outcome_t owed;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d ev %02h txid %08h att %0d",
                             result_kind_o, result_event_type_o, result_txid_o,
                             attempt_number_o));
      end else begin
        owed = pending_results.pop_front();
        n_checked++;
        kind_seen[int'(owed.kind)]++;
        if (result_kind_o !== owed.kind || result_event_type_o !== owed.ev ||
            result_txid_o !== owed.txid || attempt_number_o !== owed.att ||
            last_result_o !== owed.last)
          flag_error($sformatf({"expected kind %0d ev %02h txid %08h att %0d last %0d,",
                                " got kind %0d ev %02h txid %08h att %0d last %0d"},
                               owed.kind, owed.ev, owed.txid, owed.att, owed.last,
                               result_kind_o, result_event_type_o, result_txid_o,
                               attempt_number_o, last_result_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic push_request(req_type_e rq, logic [EvW-1:0] ev, logic [TxidW-1:0] ack);
    request_t r;
    r.rq  = rq;
    r.ev  = ev;
    r.ack = ack;
    todo_q.push_back(r);
    n_queued++;
  endtask

  // block idle: every request taken, every result delivered, scans finished
  task automatic wait_drained();
    do @(negedge clk_i); while (n_accepted != n_queued || pending_results.size() != 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_index_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RETRY_INTERVAL: cfg_interval = value;
      CFG_MAX_ATTEMPTS:   cfg_max_att  = value[AttW-1:0];
      CFG_RETRY_ENABLE:   cfg_enable   = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(logic [IvlW-1:0] ivl, logic [AttW-1:0] max_att, logic en);
    wait_drained();
    write_register(CFG_RETRY_INTERVAL, ivl);
    write_register(CFG_MAX_ATTEMPTS, {12'h0, max_att});
    write_register(CFG_RETRY_ENABLE, {15'h0, en});
    n_settings++;
  endtask

  // random requests, generated just ahead of the driver so that acks can
  // name entries that are live in the table right now
  task automatic run_random(int count);
    int               pick;
    logic [TxidW-1:0] live [$];
    logic [TxidW-1:0] ack;
    repeat (count) begin
      do @(posedge clk_i); while (todo_q.size() >= 2);
      pick = $urandom_range(0, 99);
      ack  = $urandom();
      live.delete();
      for (int i = 0; i < Depth; i++)
        if (tbl_used[i]) live.push_back(tbl[i].txid);
      if (pick < 36) begin
        push_request(REQ_QUEUE, 8'($urandom_range(0, 255)), ack);
      end else if (pick < 58) begin
        // mostly live ids, some stale recent ones, some arbitrary values
        if (live.size() > 0 && $urandom_range(0, 4) != 0)
          ack = live[$urandom_range(0, live.size() - 1)];
        else if ($urandom_range(0, 1) == 0)
          ack = txid_next - $urandom_range(1, 20);
        push_request(REQ_ACK, 8'($urandom()), ack);
      end else if (pick < 95) begin
        push_request(REQ_TICK, 8'($urandom()), ack);
      end else begin
        push_request(REQ_CLEAR, 8'($urandom()), ack);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset register values: both sends, matched and unmatched acks,
    // a tick with nothing due, clear, then a full table and an ack of its last slot
    push_request(REQ_QUEUE, 8'h00, 32'h0);
    push_request(REQ_QUEUE, 8'hFF, 32'hFFFF_FFFF);
    push_request(REQ_ACK, 8'h00, 32'd1);
    push_request(REQ_ACK, 8'hFF, 32'hFFFF_FFFF);
    push_request(REQ_ACK, 8'h00, 32'h0);
    push_request(REQ_TICK, 8'h00, 32'h0);
    push_request(REQ_CLEAR, 8'h00, 32'h0);
    for (int i = 0; i < Depth; i++)
      push_request(REQ_QUEUE, 8'(i * 17), 32'h0);
    push_request(REQ_QUEUE, 8'h5A, 32'h0);
    push_request(REQ_ACK, 8'h00, 32'd18);
    push_request(REQ_CLEAR, 8'h00, 32'h0);

    // zero interval and zero attempt limit: due on the next tick and timed out
    apply_setting(16'd0, 4'd0, 1'b1);
    push_request(REQ_QUEUE, 8'hC3, 32'h0);
    push_request(REQ_QUEUE, 8'h3C, 32'h0);
    push_request(REQ_TICK, 8'h00, 32'h0);
    push_request(REQ_TICK, 8'h00, 32'h0);

    // random phases over a spread of settings, extremes included
    apply_setting(16'd1, 4'd3, 1'b1);
    run_random(70);
    apply_setting(16'd2, 4'd15, 1'b1);
    run_random(70);
    apply_setting(16'd0, 4'd1, 1'b1);
    run_random(40);
    apply_setting(16'hFFFF, 4'd4, 1'b1);
    run_random(40);
    apply_setting(16'd3, 4'd2, 1'b0);
    run_random(30);
    apply_setting(16'd4, 4'd5, 1'b1);
    run_random(50);
    apply_setting(16'($urandom_range(1, 6)), 4'($urandom_range(1, 15)), 1'b1);
    run_random(80);

    wait_drained();
    $display("covered %0d requests under %0d register settings, %0d results checked",
             n_accepted, n_settings + 1, n_checked);
    $display("sends %0d, resends %0d, timeouts %0d, acked %0d, unmatched %0d, full %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (n_faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches in total", n_faults);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #RunLimitNs;
    $display("timeout with %0d results still owed", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== reliable_event_retry_table.f =====
hw/rtl/rert_pkg.sv
hw/rtl/rert_mem.sv
hw/rtl/reliable_event_retry_table.sv
test/tb_top.sv
